### src/bandwidth_quota_allocator_defines.svh
// ----------------------------------------------------------------------------
// bandwidth quota allocator assertion macros
// shared property forms for the allocator checks, clocked on clk, off in reset
// ----------------------------------------------------------------------------
`ifndef BANDWIDTH_QUOTA_ALLOCATOR_DEFINES_SVH
`define BANDWIDTH_QUOTA_ALLOCATOR_DEFINES_SVH

// same-cycle implication
`define BQA_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BQA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/bqa_pkg.sv
// ----------------------------------------------------------------------------
// bqa_pkg
// widths, table sizes, operation and status codes, shared alu types
// ----------------------------------------------------------------------------
package bqa_pkg;

    localparam int FUNC_W      = 3;
    localparam int CLIENT_W    = 4;
    localparam int GROUP_W     = 3;
    localparam int AMT_W       = 32;
    localparam int STATUS_W    = 2;

    localparam int NUM_CLIENTS = 1 << CLIENT_W;
    localparam int NUM_GROUPS  = 1 << GROUP_W;
    localparam int SHARE_DEPTH = NUM_GROUPS * NUM_CLIENTS;
    localparam int ADDR_W      = GROUP_W + CLIENT_W;
    localparam int IDX_W       = (CLIENT_W > GROUP_W) ? CLIENT_W : GROUP_W;

    // client, group, amount_in, keep_group rounded up to whole bytes
    localparam int S_TDATA_W   = ((CLIENT_W + GROUP_W + AMT_W + 1 + 7) / 8) * 8;
    localparam int M_TDATA_W   = ((AMT_W + 7) / 8) * 8;

    localparam logic [FUNC_W-1:0] FN_SET_GROUP     = 3'd0;
    localparam logic [FUNC_W-1:0] FN_ADD_CLIENT    = 3'd1;
    localparam logic [FUNC_W-1:0] FN_REMOVE_CLIENT = 3'd2;
    localparam logic [FUNC_W-1:0] FN_SET_ALLOC     = 3'd3;
    localparam logic [FUNC_W-1:0] FN_GET_ALLOC     = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EXISTS     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_CLIENT = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_GROUP  = 2'd3;

    typedef struct packed {
        logic             sub;
        logic [AMT_W-1:0] a;
        logic [AMT_W-1:0] b;
    } alu_req_t;

    typedef struct packed {
        logic [AMT_W-1:0] value;
        logic             lt;
    } alu_res_t;

endpackage

### src/bqa_ram.sv
// ----------------------------------------------------------------------------
// bqa_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module bqa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### src/bqa_alu.sv
// ----------------------------------------------------------------------------
// bqa_alu
// shared 32-bit add / subtract unit with borrow as unsigned less-than
// ----------------------------------------------------------------------------
module bqa_alu (
    input  bqa_pkg::alu_req_t req,
    output bqa_pkg::alu_res_t res
);

    import bqa_pkg::*;

    logic [AMT_W:0] wide;

    always_comb
    begin
        if (req.sub)
        begin
            wide = {1'b0, req.a} - {1'b0, req.b};
        end
        else
        begin
            wide = {1'b0, req.a} + {1'b0, req.b};
        end
        res.value = wide[AMT_W-1:0];
        // a < b when the subtraction borrows
        res.lt    = req.sub & wide[AMT_W];
    end

endmodule

### src/bandwidth_quota_allocator.sv
// steps to result valid: get_allocation decode, capture, done; set_allocation adds freed, over,
//   pick, smin (shrink) or want, gmin (grow), news, newt; remove_client a share ram read
//   and total update per group; group removal a share ram write per client; others decode, done
// throughput: one item at a time, next item taken the cycle after its result is registered
// reset: client and group bits, group limits and totals and share valid bits clear at once, no clearing pass
// ----------------------------------------------------------------------------
// bandwidth_quota_allocator
// per-group bandwidth limits and per-client shares, sequenced over one shared alu
// ----------------------------------------------------------------------------
`include "bandwidth_quota_allocator_defines.svh"

module bandwidth_quota_allocator (
    input  logic                              clk,
    input  logic                              rst_n,
    // input item
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // client, group, amount_in, keep_group (lowest bit up)
    input  logic [bqa_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    // func
    input  logic [bqa_pkg::FUNC_W-1:0]        s_axis_tuser,
    // result item
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // allocation_out
    output logic [bqa_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    // status
    output logic [bqa_pkg::STATUS_W-1:0]      m_axis_tuser
);

    import bqa_pkg::*;

    // sequencer states
    localparam int STATE_W = 4;
    localparam logic [STATE_W-1:0] S_IDLE    = 4'd0;
    localparam logic [STATE_W-1:0] S_DECODE  = 4'd1;
    localparam logic [STATE_W-1:0] S_CLRG    = 4'd2;   // zero shares of a removed group
    localparam logic [STATE_W-1:0] S_RMC_RD  = 4'd3;   // read share of removed client
    localparam logic [STATE_W-1:0] S_RMC_UPD = 4'd4;   // return it to the group total
    localparam logic [STATE_W-1:0] S_CAP     = 4'd5;   // capture share ram read
    localparam logic [STATE_W-1:0] S_FREED   = 4'd6;   // share - goal
    localparam logic [STATE_W-1:0] S_OVER    = 4'd7;   // total - limit
    localparam logic [STATE_W-1:0] S_PICK    = 4'd8;   // headroom, or max(over, freed)
    localparam logic [STATE_W-1:0] S_WANT    = 4'd9;   // goal - share
    localparam logic [STATE_W-1:0] S_GMIN    = 4'd10;  // min(headroom, want)
    localparam logic [STATE_W-1:0] S_SMIN    = 4'd11;  // min(share, give back)
    localparam logic [STATE_W-1:0] S_NEWS    = 4'd12;  // new share
    localparam logic [STATE_W-1:0] S_NEWT    = 4'd13;  // new total, write share back
    localparam logic [STATE_W-1:0] S_DONE    = 4'd14;

    logic [STATE_W-1:0] state_reg, state_next;

    // latched item
    logic [FUNC_W-1:0]   func_reg;
    logic [CLIENT_W-1:0] client_reg;
    logic [GROUP_W-1:0]  group_reg;
    logic [AMT_W-1:0]    amt_reg;
    logic                keep_reg;

    // tables
    logic               client_valid_reg  [NUM_CLIENTS];
    logic               group_present_reg [NUM_GROUPS];
    logic [AMT_W-1:0]   group_limit_reg   [NUM_GROUPS];
    logic [AMT_W-1:0]   group_total_reg   [NUM_GROUPS];
    logic               share_vld_reg     [SHARE_DEPTH];  // entry never written reads zero

    // walk counter for group and client sweeps
    logic [IDX_W-1:0]   idx_reg;

    // working registers of the allocation step
    logic [AMT_W-1:0]   share_reg;
    logic [AMT_W-1:0]   freed_reg;
    logic [AMT_W-1:0]   over_reg;
    logic [AMT_W-1:0]   tmp_reg;
    logic [AMT_W-1:0]   want_reg;
    logic [AMT_W-1:0]   d_reg;
    logic               lt1_reg;     // share < goal
    logic               lt2_reg;     // total < limit
    logic               rd_vld_reg;

    // pending result and output register
    logic [STATUS_W-1:0] st_reg;
    logic [AMT_W-1:0]    alloc_reg;
    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [AMT_W-1:0]    out_alloc_reg;

    // share ram
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [AMT_W-1:0]   ram_wdata;
    logic               ram_re;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [AMT_W-1:0]   ram_rdata;

    alu_req_t           alu_req;
    alu_res_t           alu_res;

    logic               accept;
    logic               grow;
    logic               g_ok;
    logic               c_ok;
    logic               grp_known;
    logic               cli_known;
    logic               out_free;
    logic [GROUP_W-1:0] tsel;
    logic [AMT_W-1:0]   tot_sel;
    logic [AMT_W-1:0]   lim_sel;
    logic [AMT_W-1:0]   rd_share;
    logic               clr_last;
    logic               rmc_last;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = M_TDATA_W'(out_alloc_reg);
    assign m_axis_tuser  = out_status_reg;
    assign out_free      = !out_valid_reg || m_axis_tready;

    // index checks stay in place for smaller table sizes
    assign g_ok      = (int'(group_reg) < NUM_GROUPS);
    assign c_ok      = (int'(client_reg) < NUM_CLIENTS);
    assign grp_known = g_ok && group_present_reg[group_reg];
    assign cli_known = c_ok && client_valid_reg[client_reg];

    // grow only while the goal is above the share and the group has headroom
    assign grow      = lt1_reg && lt2_reg;

    // total is read at the walked group during client removal, else at the item's group
    assign tsel      = (state_reg == S_RMC_UPD) ? idx_reg[GROUP_W-1:0] : group_reg;
    assign tot_sel   = group_total_reg[tsel];
    assign lim_sel   = group_limit_reg[group_reg];
    assign rd_share  = rd_vld_reg ? ram_rdata : '0;

    assign clr_last  = (idx_reg[CLIENT_W-1:0] == CLIENT_W'(NUM_CLIENTS - 1));
    assign rmc_last  = (idx_reg[GROUP_W-1:0] == GROUP_W'(NUM_GROUPS - 1));

    bqa_ram #(
        .WIDTH (AMT_W),
        .DEPTH (SHARE_DEPTH)
    ) u_share_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bqa_alu u_alu (
        .req (alu_req),
        .res (alu_res)
    );

    // share ram port control
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = {group_reg, client_reg};
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = {group_reg, client_reg};
        unique case (state_reg)
            S_DECODE:
            begin
                // speculative read for set and get allocation
                ram_re = 1'b1;
            end
            S_RMC_RD:
            begin
                ram_re    = 1'b1;
                ram_raddr = {idx_reg[GROUP_W-1:0], client_reg};
            end
            S_CLRG:
            begin
                ram_we    = 1'b1;
                ram_waddr = {group_reg, idx_reg[CLIENT_W-1:0]};
            end
            S_RMC_UPD:
            begin
                ram_we    = 1'b1;
                ram_waddr = {idx_reg[GROUP_W-1:0], client_reg};
            end
            S_NEWT:
            begin
                ram_we    = 1'b1;
                ram_wdata = share_reg;
            end
            default:
            begin
            end
        endcase
    end

    // operand selection for the shared alu
    always_comb
    begin
        alu_req.sub = 1'b1;
        alu_req.a   = '0;
        alu_req.b   = '0;
        unique case (state_reg)
            S_RMC_UPD:
            begin
                alu_req.a = tot_sel;
                alu_req.b = rd_share;
            end
            S_FREED:
            begin
                alu_req.a = share_reg;
                alu_req.b = amt_reg;
            end
            S_OVER:
            begin
                alu_req.a = tot_sel;
                alu_req.b = lim_sel;
            end
            S_PICK:
            begin
                if (grow)
                begin
                    alu_req.a = lim_sel;
                    alu_req.b = tot_sel;
                end
                else
                begin
                    alu_req.a = over_reg;
                    alu_req.b = freed_reg;
                end
            end
            S_WANT:
            begin
                alu_req.a = amt_reg;
                alu_req.b = share_reg;
            end
            S_GMIN:
            begin
                alu_req.a = tmp_reg;
                alu_req.b = want_reg;
            end
            S_SMIN:
            begin
                alu_req.a = share_reg;
                alu_req.b = tmp_reg;
            end
            S_NEWS:
            begin
                alu_req.sub = !grow;
                alu_req.a   = share_reg;
                alu_req.b   = d_reg;
            end
            S_NEWT:
            begin
                alu_req.sub = !grow;
                alu_req.a   = tot_sel;
                alu_req.b   = d_reg;
            end
            default:
            begin
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (func_reg) inside
                    FN_SET_GROUP:
                    begin
                        state_next = (g_ok && !keep_reg) ? S_CLRG : S_DONE;
                    end
                    FN_REMOVE_CLIENT:
                    begin
                        state_next = cli_known ? S_RMC_RD : S_DONE;
                    end
                    FN_SET_ALLOC, FN_GET_ALLOC:
                    begin
                        state_next = (grp_known && cli_known) ? S_CAP : S_DONE;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_CLRG:
            begin
                if (clr_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_RMC_RD:
            begin
                state_next = S_RMC_UPD;
            end
            S_RMC_UPD:
            begin
                state_next = rmc_last ? S_DONE : S_RMC_RD;
            end
            S_CAP:
            begin
                state_next = (func_reg == FN_GET_ALLOC) ? S_DONE : S_FREED;
            end
            S_FREED:
            begin
                state_next = S_OVER;
            end
            S_OVER:
            begin
                state_next = S_PICK;
            end
            S_PICK:
            begin
                state_next = grow ? S_WANT : S_SMIN;
            end
            S_WANT:
            begin
                state_next = S_GMIN;
            end
            S_GMIN, S_SMIN:
            begin
                state_next = S_NEWS;
            end
            S_NEWS:
            begin
                state_next = S_NEWT;
            end
            S_NEWT:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state and tables
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_CLIENTS; i++)
            begin
                client_valid_reg[i] <= 1'b0;
            end
            for (int i = 0; i < NUM_GROUPS; i++)
            begin
                group_present_reg[i] <= 1'b0;
                group_limit_reg[i]   <= '0;
                group_total_reg[i]   <= '0;
            end
            for (int i = 0; i < SHARE_DEPTH; i++)
            begin
                share_vld_reg[i] <= 1'b0;
            end
        end
        else
        begin
            state_reg <= state_next;

            if (ram_we)
            begin
                share_vld_reg[ram_waddr] <= 1'b1;
            end

            if (state_reg == S_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_DECODE:
                begin
                    idx_reg <= '0;
                    unique case (func_reg) inside
                        FN_SET_GROUP:
                        begin
                            if (g_ok)
                            begin
                                group_present_reg[group_reg] <= keep_reg;
                                if (keep_reg)
                                begin
                                    group_limit_reg[group_reg] <= amt_reg;
                                end
                                else
                                begin
                                    group_limit_reg[group_reg] <= '0;
                                    group_total_reg[group_reg] <= '0;
                                end
                            end
                        end
                        FN_ADD_CLIENT:
                        begin
                            if (c_ok && !client_valid_reg[client_reg])
                            begin
                                client_valid_reg[client_reg] <= 1'b1;
                            end
                        end
                        FN_REMOVE_CLIENT:
                        begin
                            if (cli_known)
                            begin
                                client_valid_reg[client_reg] <= 1'b0;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                S_CLRG:
                begin
                    idx_reg <= idx_reg + IDX_W'(1);
                end
                S_RMC_UPD:
                begin
                    // absent groups hold no total to give back to
                    if (group_present_reg[tsel])
                    begin
                        group_total_reg[tsel] <= alu_res.value;
                    end
                    idx_reg <= idx_reg + IDX_W'(1);
                end
                S_NEWT:
                begin
                    group_total_reg[group_reg] <= alu_res.value;
                end
                default:
                begin
                end
            endcase
        end
    end

    // item payload and working registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            client_reg <= s_axis_tdata[CLIENT_W-1:0];
            group_reg  <= s_axis_tdata[CLIENT_W +: GROUP_W];
            amt_reg    <= s_axis_tdata[CLIENT_W + GROUP_W +: AMT_W];
            keep_reg   <= s_axis_tdata[CLIENT_W + GROUP_W + AMT_W];
            func_reg   <= s_axis_tuser;
            st_reg     <= ST_OK;
            alloc_reg  <= '0;
        end

        if (ram_re)
        begin
            rd_vld_reg <= share_vld_reg[ram_raddr];
        end

        if (state_reg == S_DONE && out_free)
        begin
            out_status_reg <= st_reg;
            out_alloc_reg  <= alloc_reg;
        end

        unique case (state_reg)
            S_DECODE:
            begin
                unique case (func_reg) inside
                    FN_ADD_CLIENT:
                    begin
                        if (!c_ok)
                        begin
                            st_reg <= ST_BAD_CLIENT;
                        end
                        else if (client_valid_reg[client_reg])
                        begin
                            st_reg <= ST_EXISTS;
                        end
                    end
                    FN_REMOVE_CLIENT:
                    begin
                        if (!cli_known)
                        begin
                            st_reg <= ST_BAD_CLIENT;
                        end
                    end
                    FN_SET_ALLOC, FN_GET_ALLOC:
                    begin
                        // group is checked before client
                        if (!grp_known)
                        begin
                            st_reg <= ST_BAD_GROUP;
                        end
                        else if (!cli_known)
                        begin
                            st_reg <= ST_BAD_CLIENT;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_CAP:
            begin
                share_reg <= rd_share;
                alloc_reg <= rd_share;
            end
            S_FREED:
            begin
                freed_reg <= alu_res.lt ? '0 : alu_res.value;
                lt1_reg   <= alu_res.lt;
            end
            S_OVER:
            begin
                over_reg <= alu_res.lt ? '0 : alu_res.value;
                lt2_reg  <= alu_res.lt;
            end
            S_PICK:
            begin
                if (grow)
                begin
                    tmp_reg <= alu_res.value;
                end
                else
                begin
                    tmp_reg <= alu_res.lt ? freed_reg : over_reg;
                end
            end
            S_WANT:
            begin
                want_reg <= alu_res.value;
            end
            S_GMIN:
            begin
                d_reg <= alu_res.lt ? tmp_reg : want_reg;
            end
            S_SMIN:
            begin
                d_reg <= alu_res.lt ? share_reg : tmp_reg;
            end
            S_NEWS:
            begin
                share_reg <= alu_res.value;
            end
            S_NEWT:
            begin
                alloc_reg <= share_reg;
            end
            default:
            begin
            end
        endcase
    end

    // an accepted item always goes to decode next
    `BQA_ASSERT_NEXT(a_accept_decode, accept, state_reg == S_DECODE, "accept did not decode")

    // growing never pushes the group total past its limit
    `BQA_ASSERT_SAME(a_grow_in_limit, (state_reg == S_NEWT) && grow,
                     !(alu_res.value > lim_sel), "grow exceeds group limit")

    // shrinking never gives back more than the client holds
    `BQA_ASSERT_SAME(a_shrink_no_wrap, (state_reg == S_NEWS) && !grow, !alu_res.lt,
                     "shrink underflows share")

    // share ram is written only by sweeps and the write-back step
    `BQA_ASSERT_SAME(a_ram_we_state, ram_we,
                     (state_reg == S_CLRG) || (state_reg == S_RMC_UPD) || (state_reg == S_NEWT),
                     "unexpected share ram write")

endmodule

### tb/sv/bandwidth_quota_allocator_checker.sv
// ----------------------------------------------------------------------------
// bandwidth quota allocator checker
// watches both stream channels, predicts each result from its own copy of the
// group, client and share tables, and compares results in order
// ----------------------------------------------------------------------------
module bandwidth_quota_allocator_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    input  logic                              s_axis_tready,
    input  logic [bqa_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    input  logic [bqa_pkg::FUNC_W-1:0]        s_axis_tuser,
    input  logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic [bqa_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    input  logic [bqa_pkg::STATUS_W-1:0]      m_axis_tuser,
    output int unsigned                       failures,
    output int unsigned                       pending
);
    import bqa_pkg::*;

    localparam int GROUP_LSB  = CLIENT_W;
    localparam int AMT_LSB    = CLIENT_W + GROUP_W;
    localparam int KEEP_BIT   = AMT_LSB + AMT_W;
    localparam int MAX_REPORT = 10;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [AMT_W-1:0]    share;
    } grant_t;

    bit               registered [NUM_CLIENTS];
    bit               group_live [NUM_GROUPS];
    logic [AMT_W-1:0] group_cap  [NUM_GROUPS];
    logic [AMT_W-1:0] group_sum  [NUM_GROUPS];
    logic [AMT_W-1:0] share_tbl  [NUM_GROUPS][NUM_CLIENTS];

    grant_t grant_q[$];

    // applies one request to the tables and returns the result it causes
    function automatic grant_t predict_grant(
        input logic [FUNC_W-1:0]   fn,
        input logic [CLIENT_W-1:0] cl,
        input logic [GROUP_W-1:0]  gr,
        input logic [AMT_W-1:0]    amt,
        input logic                keep
    );
        grant_t           r;
        logic [AMT_W-1:0] cur;
        logic [AMT_W-1:0] lim;
        logic [AMT_W-1:0] tot;
        logic [AMT_W-1:0] d;
        logic [AMT_W-1:0] over;
        logic [AMT_W-1:0] freed;
        r.status = ST_OK;
        r.share  = '0;
        case (fn)
            FN_SET_GROUP:
            begin
                if (keep)
                begin
                    group_live[gr] = 1'b1;
                    group_cap[gr]  = amt;
                end
                else
                begin
                    group_live[gr] = 1'b0;
                    group_cap[gr]  = '0;
                    group_sum[gr]  = '0;
                    for (int k = 0; k < NUM_CLIENTS; k++)
                        share_tbl[gr][k] = '0;
                end
            end
            FN_ADD_CLIENT:
            begin
                if (registered[cl])
                    r.status = ST_EXISTS;
                else
                    registered[cl] = 1'b1;
            end
            FN_REMOVE_CLIENT:
            begin
                if (!registered[cl])
                    r.status = ST_BAD_CLIENT;
                else
                begin
                    registered[cl] = 1'b0;
                    for (int k = 0; k < NUM_GROUPS; k++)
                    begin
                        if (group_live[k])
                            group_sum[k] = group_sum[k] - share_tbl[k][cl];
                        share_tbl[k][cl] = '0;
                    end
                end
            end
            FN_SET_ALLOC, FN_GET_ALLOC:
            begin
                if (!group_live[gr])
                    r.status = ST_BAD_GROUP;
                else if (!registered[cl])
                    r.status = ST_BAD_CLIENT;
                else
                begin
                    cur = share_tbl[gr][cl];
                    if (fn == FN_SET_ALLOC)
                    begin
                        lim = group_cap[gr];
                        tot = group_sum[gr];
                        if (amt > cur && tot < lim)
                        begin
                            // grow, bounded by the group headroom
                            d = (lim - tot < amt - cur) ? lim - tot : amt - cur;
                            cur = cur + d;
                            group_sum[gr] = tot + d;
                        end
                        else
                        begin
                            // shrink by the larger of overallocation and excess
                            over  = (tot > lim) ? tot - lim : '0;
                            freed = (cur > amt) ? cur - amt : '0;
                            d = (over > freed) ? over : freed;
                            if (d > cur)
                                d = cur;
                            cur = cur - d;
                            group_sum[gr] = tot - d;
                        end
                        share_tbl[gr][cl] = cur;
                    end
                    r.share = cur;
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        grant_t want;
        if (!rst_n)
        begin
            for (int g = 0; g < NUM_GROUPS; g++)
            begin
                group_live[g] = 1'b0;
                group_cap[g]  = '0;
                group_sum[g]  = '0;
                for (int c = 0; c < NUM_CLIENTS; c++)
                    share_tbl[g][c] = '0;
            end
            for (int c = 0; c < NUM_CLIENTS; c++)
                registered[c] = 1'b0;
            grant_q.delete();
            failures <= 0;
            pending  <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                grant_q.push_back(predict_grant(s_axis_tuser,
                                                s_axis_tdata[CLIENT_W-1:0],
                                                s_axis_tdata[GROUP_LSB +: GROUP_W],
                                                s_axis_tdata[AMT_LSB +: AMT_W],
                                                s_axis_tdata[KEEP_BIT]));
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (grant_q.size() == 0)
                begin
                    if (failures < MAX_REPORT)
                        $display("%0t: result with none outstanding: status %0d allocation %0h",
                                 $time, m_axis_tuser, m_axis_tdata[AMT_W-1:0]);
                    failures <= failures + 1;
                end
                else
                begin
                    want = grant_q.pop_front();
                    if (m_axis_tuser !== want.status || m_axis_tdata[AMT_W-1:0] !== want.share)
                    begin
                        if (failures < MAX_REPORT)
                            $display("%0t: mismatch: status exp %0d got %0d, allocation exp %0h got %0h",
                                     $time, want.status, m_axis_tuser,
                                     want.share, m_axis_tdata[AMT_W-1:0]);
                        failures <= failures + 1;
                    end
                end
            end
            pending <= grant_q.size();
        end
    end

endmodule

### tb/sv/bandwidth_quota_allocator_tb.sv
// ----------------------------------------------------------------------------
// bandwidth quota allocator testbench
// directed group, client and allocation sequences, then random traffic under
// several sender and receiver idling mixes and one long receiver hold-off
// ----------------------------------------------------------------------------
module bandwidth_quota_allocator_tb;
    import bqa_pkg::*;

    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 8;
    localparam int IDLE_LIMIT    = 4000;   // cycles with no item moving on either side
    localparam int HOLD_CYCLES   = 300;    // long receiver hold-off
    localparam int DRAIN_CYCLES  = 40;
    localparam int PHASE_ITEMS   = 350;
    localparam int SMALL_AMT_MAX = 400;    // small values make groups run out of headroom

    localparam logic [FUNC_W-1:0] FN_FIRST_UNUSED = FN_GET_ALLOC + 1'b1;
    localparam int                FN_LAST         = (1 << FUNC_W) - 1;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata = '0;   // client, group, amount_in, keep_group
    logic [FUNC_W-1:0]     s_axis_tuser = '0;   // func
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_axis_tdata;        // allocation_out
    logic [STATUS_W-1:0]   m_axis_tuser;        // status

    int unsigned failures;
    int unsigned pending;

    // idling controls, changed by the stimulus between phases
    int unsigned send_gap_pct = 0;
    int unsigned rx_stall_pct = 0;
    bit          hold_req = 1'b0;
    bit          hold_rx = 1'b0;
    int unsigned quiet_cycles = 0;

    bandwidth_quota_allocator dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    bandwidth_quota_allocator_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .failures      (failures),
        .pending       (pending)
    );

    always #HALF_PERIOD clk = ~clk;

    // receiver: random stalls, or held low entirely during the hold-off
    always @(negedge clk)
        m_axis_tready = !hold_rx && ($urandom_range(99) >= rx_stall_pct);

    // long hold-off, counted here while the sender keeps offering items;
    // hold_rx moves on rising edges so the receiver reads it race free
    initial
    begin
        wait (hold_req);
        @(posedge clk);
        hold_rx = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rx = 1'b0;
    end

    // watchdog on cycles in which no item moves
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("FAIL bandwidth_quota_allocator");
            $finish;
        end
    end

    // present one item at a falling edge and hold it until accepted;
    // valid stays high between back-to-back items
    task automatic offer_item(
        input logic [FUNC_W-1:0]   fn,
        input logic [CLIENT_W-1:0] cl,
        input logic [GROUP_W-1:0]  gr,
        input logic [AMT_W-1:0]    amt,
        input logic                keep
    );
        @(negedge clk);
        while ($urandom_range(99) < send_gap_pct)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = fn;
        s_axis_tdata  = {keep, amt, gr, cl};
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // mostly small values, with the extremes and full-width values mixed in
    function automatic logic [AMT_W-1:0] pick_amount();
        int unsigned r;
        r = $urandom_range(9);
        if (r == 0)
            return '0;
        else if (r == 1)
            return '1;
        else if (r < 4)
            return $urandom;
        else
            return $urandom_range(SMALL_AMT_MAX);
    endfunction

    // weighted toward allocation traffic on random clients and groups,
    // with removals and unused codes as noise
    task automatic offer_random_item();
        int unsigned       pick;
        logic [FUNC_W-1:0] fn;
        logic              keep;
        pick = $urandom_range(99);
        keep = 1'($urandom_range(1));
        if (pick < 8)
        begin
            fn   = FN_SET_GROUP;
            keep = 1'b1;
        end
        else if (pick < 11)
        begin
            fn   = FN_SET_GROUP;
            keep = 1'b0;
        end
        else if (pick < 21)
            fn = FN_ADD_CLIENT;
        else if (pick < 26)
            fn = FN_REMOVE_CLIENT;
        else if (pick < 70)
            fn = FN_SET_ALLOC;
        else if (pick < 95)
            fn = FN_GET_ALLOC;
        else
            fn = FUNC_W'($urandom_range(FN_LAST, FN_FIRST_UNUSED));
        offer_item(fn, CLIENT_W'($urandom_range(NUM_CLIENTS - 1)),
                   GROUP_W'($urandom_range(NUM_GROUPS - 1)), pick_amount(), keep);
    endtask

    task automatic run_phase(input int unsigned gap, input int unsigned stall,
                             input int unsigned count);
        send_gap_pct = gap;
        rx_stall_pct = stall;
        repeat (count) offer_random_item();
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // nothing exists yet: group checked before client
        offer_item(FN_GET_ALLOC, 4'd0, 3'd0, '0, 1'b0);
        offer_item(FN_SET_ALLOC, 4'd15, 3'd7, '1, 1'b1);
        offer_item(FN_SET_GROUP, 4'd0, 3'd0, 32'd100, 1'b1);
        offer_item(FN_GET_ALLOC, 4'd0, 3'd0, '0, 1'b0);
        // unknown client removal, then add and duplicate add
        offer_item(FN_REMOVE_CLIENT, 4'd15, 3'd0, '0, 1'b0);
        offer_item(FN_ADD_CLIENT, 4'd0, 3'd0, '0, 1'b0);
        offer_item(FN_ADD_CLIENT, 4'd0, 3'd0, '0, 1'b0);
        offer_item(FN_ADD_CLIENT, 4'd15, 3'd7, '1, 1'b1);
        // growth up to the goal, then capped by headroom
        offer_item(FN_SET_ALLOC, 4'd0, 3'd0, 32'd70, 1'b0);
        offer_item(FN_SET_ALLOC, 4'd15, 3'd0, '1, 1'b0);
        // lowered limit leaves the group overallocated, shares kept
        offer_item(FN_SET_GROUP, 4'd0, 3'd0, 32'd40, 1'b1);
        offer_item(FN_SET_ALLOC, 4'd0, 3'd0, 32'd70, 1'b0);
        offer_item(FN_SET_ALLOC, 4'd15, 3'd0, 32'd10, 1'b0);
        offer_item(FN_GET_ALLOC, 4'd15, 3'd0, '0, 1'b0);
        // full-scale limit and share
        offer_item(FN_SET_GROUP, 4'd0, 3'd7, '1, 1'b1);
        offer_item(FN_SET_ALLOC, 4'd15, 3'd7, '1, 1'b0);
        // client removal returns its share in every group
        offer_item(FN_REMOVE_CLIENT, 4'd15, 3'd0, '0, 1'b0);
        offer_item(FN_ADD_CLIENT, 4'd15, 3'd0, '0, 1'b0);
        offer_item(FN_GET_ALLOC, 4'd15, 3'd7, '0, 1'b0);
        // group removal clears shares; removing an absent group is harmless
        offer_item(FN_SET_GROUP, 4'd0, 3'd0, '1, 1'b0);
        offer_item(FN_SET_GROUP, 4'd0, 3'd0, '0, 1'b0);
        offer_item(FN_GET_ALLOC, 4'd0, 3'd0, '0, 1'b0);
        // unused function codes are ignored
        for (int f = FN_FIRST_UNUSED; f <= FN_LAST; f++)
            offer_item(FUNC_W'(f), 4'd15, 3'd7, '1, 1'b1);

        run_phase(0, 0, PHASE_ITEMS);
        run_phase(49, 0, PHASE_ITEMS);
        run_phase(0, 49, PHASE_ITEMS);
        run_phase(34, 34, PHASE_ITEMS);

        // receiver held off while the sender streams: the block backs up
        hold_req = 1'b1;
        run_phase(0, 0, 150);

        @(negedge clk);
        s_axis_tvalid = 1'b0;
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (failures == 0 && pending == 0)
            $display("PASS bandwidth_quota_allocator");
        else
            $display("FAIL bandwidth_quota_allocator");
        $finish;
    end

endmodule

### bandwidth_quota_allocator.f
+incdir+src
src/bqa_pkg.sv
src/bqa_ram.sv
src/bqa_alu.sv
src/bandwidth_quota_allocator.sv
tb/sv/bandwidth_quota_allocator_checker.sv
tb/sv/bandwidth_quota_allocator_tb.sv
